// ----- rtl/crcc_pkg.sv -----
// Package for the CRC codeword stream checker.
// Holds the configuration and result types, register indexes and fixed widths.
// No dependencies; every other file of the block imports it.
`default_nettype none

package crcc_pkg;

    // Fixed field widths.
    localparam int BYTE_W      = 8;
    localparam int GEN_BITS_W  = 9;
    localparam int GEN_LEN_W   = 4;
    localparam int TOTAL_W     = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    // Dataword sizes selected by the wide register.
    localparam logic [3:0] DSIZE_NARROW = 4'd4;
    localparam logic [3:0] DSIZE_WIDE   = 4'd8;

    // Result queue depth and pointer width.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_GEN_BITS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GEN_LEN  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDE     = 2'd2;

    // Configuration reset values.
    localparam logic [GEN_BITS_W-1:0] GEN_BITS_RESET = 9'd11;
    localparam logic [GEN_LEN_W-1:0]  GEN_LEN_RESET  = 4'd4;
    localparam logic                  WIDE_RESET     = 1'b1;

    // Result kinds.
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [GEN_BITS_W-1:0] gen_bits;
        logic [GEN_LEN_W-1:0]  gen_len;
        logic                  wide;
    } t_cfg;

    typedef struct packed {
        logic               kind;
        logic [BYTE_W-1:0]  dbyte;
        logic [TOTAL_W-1:0] cw_total;
        logic [TOTAL_W-1:0] er_total;
        logic               run_end;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/crc_codeword_stream_checker.sv -----
// Top level of the CRC codeword stream checker.
// Instantiates crcc_cfg, crcc_core and crcc_outq; depends on crcc_pkg.
//
//   Channel   Direction  Handshake                   Payload
//   in        to block   i_in_valid / o_in_ready     i_stream_byte, i_final_byte
//   out       from block o_out_valid / i_out_ready   o_result_kind, o_decoded_byte,
//                                                    o_codeword_total, o_error_total,
//                                                    o_run_end
//   cfg       to block   i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One byte per cycle while the result queue has room: a request is held in the input
// register, its eight bit steps run in one pass, and its results are written into a
// four-entry queue. The final byte with a data byte gives two results, which drain
// one per cycle while i_out_ready is high.
// Reset is synchronous and active low and needs no clearing pass.
// The input stalls only while the result queue lacks room for two results.
`default_nettype none

module crc_codeword_stream_checker #(
    parameter int MAX_GENERATOR_LENGTH = 9,
    parameter int COUNTER_WIDTH        = 24
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [crcc_pkg::BYTE_W-1:0]      i_stream_byte,
    input  wire logic                             i_final_byte,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_result_kind,
    output logic [crcc_pkg::BYTE_W-1:0]           o_decoded_byte,
    output logic [crcc_pkg::TOTAL_W-1:0]          o_codeword_total,
    output logic [crcc_pkg::TOTAL_W-1:0]          o_error_total,
    output logic                                  o_run_end,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [crcc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [crcc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import crcc_pkg::*;

    t_cfg       cfg;
    logic       room;
    logic [1:0] push_n;
    t_result    res0;
    t_result    res1;
    t_result    head;

    // Configuration registers.
    crcc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Byte datapath.
    crcc_core #(
        .MAX_GENERATOR_LENGTH (MAX_GENERATOR_LENGTH),
        .COUNTER_WIDTH        (COUNTER_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_stream_byte (i_stream_byte),
        .i_final_byte  (i_final_byte),
        .i_room        (room),
        .o_push_n      (push_n),
        .o_res0        (res0),
        .o_res1        (res1)
    );

    // Result queue.
    crcc_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_n    (push_n),
        .i_res0      (res0),
        .i_res1      (res1),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (head)
    );

    assign o_result_kind    = head.kind;
    assign o_decoded_byte   = head.dbyte;
    assign o_codeword_total = head.cw_total;
    assign o_error_total    = head.er_total;
    assign o_run_end        = head.run_end;

endmodule

`default_nettype wire

// ----- rtl/crcc_cfg.sv -----
// Configuration registers of the CRC codeword stream checker.
// Depends on crcc_pkg for the register indexes, reset values and t_cfg.
`default_nettype none

module crcc_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [crcc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [crcc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output crcc_pkg::t_cfg                        o_cfg
);
    import crcc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // The registers take a write in any cycle.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Decode the register index; unknown indexes are ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GEN_BITS: n_cfg.gen_bits = i_cfg_data[GEN_BITS_W-1:0];
                CFG_GEN_LEN:  n_cfg.gen_len  = i_cfg_data[GEN_LEN_W-1:0];
                CFG_WIDE:     n_cfg.wide     = i_cfg_data[0];
                default:      n_cfg          = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gen_bits <= GEN_BITS_RESET;
            r_cfg.gen_len  <= GEN_LEN_RESET;
            r_cfg.wide     <= WIDE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/crcc_core.sv -----
// Input register and single-pass byte datapath of the CRC codeword stream checker:
// padding skip, eight unrolled division steps, dataword packing and saturating counts.
// Depends on crcc_pkg for t_cfg, t_result and the fixed widths.
`default_nettype none

module crcc_core #(
    parameter int MAX_GENERATOR_LENGTH = 9,
    parameter int COUNTER_WIDTH        = 24
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire crcc_pkg::t_cfg              i_cfg,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [crcc_pkg::BYTE_W-1:0] i_stream_byte,
    input  wire logic                        i_final_byte,
    input  wire logic                        i_room,
    output logic [1:0]                       o_push_n,
    output crcc_pkg::t_result                o_res0,
    output crcc_pkg::t_result                o_res1
);
    import crcc_pkg::*;

    localparam int MGL = MAX_GENERATOR_LENGTH;
    localparam int LW  = $clog2(MGL + 1);
    localparam int CBW = $clog2(MGL + 8);
    localparam int CW  = COUNTER_WIDTH;

    // Input register.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_fin;

    // Stream state.
    logic              r_header;
    logic [7:0]        r_skip;
    logic [MGL-1:0]    r_win;
    logic [CBW-1:0]    r_cnt;
    logic [7:0]        r_hold;
    logic [7:0]        r_pack;
    logic [3:0]        r_pcnt;
    logic [CW-1:0]     r_cw;
    logic [CW-1:0]     r_er;

    logic              n_header;
    logic [7:0]        n_skip;
    logic [MGL-1:0]    n_win;
    logic [CBW-1:0]    n_cnt;
    logic [7:0]        n_hold;
    logic [7:0]        n_pack;
    logic [3:0]        n_pcnt;
    logic [CW-1:0]     n_cw;
    logic [CW-1:0]     n_er;

    logic              fire;
    logic [LW-1:0]     len;
    logic [MGL-1:0]    m;
    logic [MGL-1:0]    topbit;
    logic [MGL-1:0]    genm;
    logic [3:0]        dsize;
    logic [CBW-1:0]    len_m1;
    logic [CBW-1:0]    clen_m1;
    logic [1:0]        cw_inc;
    logic [1:0]        er_inc;
    logic              made;
    logic [7:0]        dbyte;
    logic [CW:0]       cw_sum;
    logic [CW:0]       er_sum;
    logic [1:0]        push_n;
    t_result           res0;
    t_result           res1;

    // An item is taken when the stage is empty or its item moves on this cycle.
    assign fire       = r_in_valid & i_room;
    assign o_in_ready = !r_in_valid || i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_stream_byte;
            r_fin  <= i_final_byte;
        end
    end

    // Generator length clamped to 1..MAX_GENERATOR_LENGTH, window masks and codeword size.
    always_comb begin
        if (i_cfg.gen_len == '0) begin
            len = LW'(1);
        end else if (32'(i_cfg.gen_len) > 32'(MGL)) begin
            len = LW'(MGL);
        end else begin
            len = LW'(i_cfg.gen_len);
        end
        for (int k = 0; k < MGL; k++) begin
            m[k] = (k < 32'(len));
        end
        topbit  = m ^ (m >> 1);
        genm    = MGL'(i_cfg.gen_bits) & m;
        dsize   = i_cfg.wide ? DSIZE_WIDE : DSIZE_NARROW;
        len_m1  = CBW'(len) - CBW'(1);
        clen_m1 = CBW'(dsize) + len_m1 - CBW'(1);
    end

    // One pass over the eight bits of the byte, most significant first.
    always_comb begin
        logic [MGL-1:0] win;
        logic [CBW-1:0] cnt;
        logic [7:0]     hold;
        logic [15:0]    pack;
        logic [3:0]     pcnt;
        logic [7:0]     skip;
        logic           b;

        win    = r_win;
        cnt    = r_cnt;
        hold   = r_hold;
        pack   = {8'd0, r_pack};
        pcnt   = r_pcnt;
        skip   = r_skip;
        b      = 1'b0;
        cw_inc = 2'd0;
        er_inc = 2'd0;
        made   = 1'b0;
        dbyte  = 8'd0;

        for (int i = 7; i >= 0; i--) begin
            b = r_byte[i];
            if (skip != 8'd0) begin
                skip = skip - 8'd1;
            end else begin
                // Shift the bit into the window and subtract the generator.
                win = ((win << 1) | MGL'(b)) & m;
                if (cnt >= len_m1 && (win & topbit) != '0) begin
                    win = win ^ genm;
                end
                if (cnt < CBW'(dsize)) begin
                    hold = {hold[6:0], b};
                end
                // Codeword complete: count it and pack its dataword.
                if (cnt >= clen_m1) begin
                    cw_inc = cw_inc + 2'd1;
                    if ((win & (m >> 1)) != '0) begin
                        er_inc = er_inc + 2'd1;
                    end
                    if (i_cfg.wide) begin
                        pack = {pack[7:0], hold};
                    end else begin
                        pack = {pack[11:0], hold[3:0]};
                    end
                    pcnt = pcnt + dsize;
                    if (pcnt >= 4'd8) begin
                        pcnt = pcnt - 4'd8;
                        if (!made) begin
                            dbyte = 8'(pack >> pcnt);
                            made  = 1'b1;
                        end
                    end
                    pack = pack & ((16'd1 << pcnt) - 16'd1);
                    win  = '0;
                    cnt  = '0;
                    hold = 8'd0;
                end else begin
                    cnt = cnt + CBW'(1);
                end
            end
        end

        n_win  = win;
        n_cnt  = cnt;
        n_hold = hold;
        n_pack = pack[7:0];
        n_pcnt = pcnt;
        n_skip = skip;
    end

    // Saturating counter sums; at most two codewords end within one byte.
    assign cw_sum = {1'b0, r_cw} + (CW+1)'(cw_inc);
    assign er_sum = {1'b0, r_er} + (CW+1)'(er_inc);

    // Next state and the results of this byte.
    always_comb begin
        logic [CW-1:0] cw_next;
        logic [CW-1:0] er_next;
        logic          data_ok;

        cw_next  = cw_sum[CW] ? '1 : cw_sum[CW-1:0];
        er_next  = er_sum[CW] ? '1 : er_sum[CW-1:0];
        data_ok  = r_header && made;

        n_header = 1'b1;
        n_cw     = r_cw;
        n_er     = r_er;
        if (r_header) begin
            n_cw = cw_next;
            n_er = er_next;
        end

        res0          = '0;
        res1          = '0;
        res0.kind     = KIND_DATA;
        res0.dbyte    = dbyte;
        res1.kind     = KIND_SUMMARY;
        res1.cw_total = TOTAL_W'(n_cw);
        res1.er_total = TOTAL_W'(n_er);

        if (data_ok && r_fin) begin
            push_n       = 2'd2;
            res1.run_end = 1'b1;
        end else if (data_ok) begin
            push_n       = 2'd1;
            res0.run_end = 1'b1;
        end else if (r_fin) begin
            push_n       = 2'd1;
            res0         = res1;
            res0.run_end = 1'b1;
        end else begin
            push_n = 2'd0;
        end
    end

    assign o_push_n = fire ? push_n : 2'd0;
    assign o_res0   = res0;
    assign o_res1   = res1;

    // State update; the padding byte loads the skip count and sets the header flag, the final byte clears all.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= 1'b0;
            r_skip   <= 8'd0;
            r_win    <= '0;
            r_cnt    <= '0;
            r_hold   <= 8'd0;
            r_pack   <= 8'd0;
            r_pcnt   <= 4'd0;
            r_cw     <= '0;
            r_er     <= '0;
        end else if (fire) begin
            if (r_fin) begin
                r_header <= 1'b0;
                r_skip   <= 8'd0;
                r_win    <= '0;
                r_cnt    <= '0;
                r_hold   <= 8'd0;
                r_pack   <= 8'd0;
                r_pcnt   <= 4'd0;
                r_cw     <= '0;
                r_er     <= '0;
            end else if (!r_header) begin
                r_header <= n_header;
                r_skip   <= r_byte;
            end else begin
                r_skip   <= n_skip;
                r_win    <= n_win;
                r_cnt    <= n_cnt;
                r_hold   <= n_hold;
                r_pack   <= n_pack;
                r_pcnt   <= n_pcnt;
                r_cw     <= n_cw;
                r_er     <= n_er;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/crcc_outq.sv -----
// Result queue of the CRC codeword stream checker: takes up to two results
// per cycle and hands out one. Depends on crcc_pkg for t_result and the depth.
`default_nettype none

module crcc_outq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [1:0]        i_push_n,
    input  wire crcc_pkg::t_result i_res0,
    input  wire crcc_pkg::t_result i_res1,
    output logic                   o_room,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output crcc_pkg::t_result      o_res
);
    import crcc_pkg::*;

    t_result               r_entry [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0]   r_wptr;
    logic [QUEUE_PW-1:0]   r_rptr;
    logic [QUEUE_CW-1:0]   r_count;
    logic [QUEUE_PW-1:0]   wptr1;
    logic                  pop;

    assign wptr1       = r_wptr + QUEUE_PW'(1);
    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid && i_out_ready;
    assign o_res       = r_entry[r_rptr];
    // Room for the two results a byte may cause.
    assign o_room      = (r_count <= QUEUE_CW'(QUEUE_DEPTH - 2));

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_entry[r_wptr] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_entry[wptr1] <= i_res1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + QUEUE_PW'(i_push_n);
            r_rptr  <= r_rptr + QUEUE_PW'(pop);
            r_count <= r_count + QUEUE_CW'(i_push_n) - QUEUE_CW'(pop);
        end
    end

endmodule

`default_nettype wire
